FILE: sv/ssm_pkg.sv
// shared constants, types and helpers for the substring stream matcher
package ssm_pkg;

	// window depth and byte counter width
	localparam int PATTERN_MAX = 16;
	localparam int COUNT_WIDTH = 32;

	// pattern store holds sixteen bytes, higher pattern indexes read as zero
	localparam int PAT_BYTES   = 16;
	localparam int CFG_LEN_W   = 5;
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_INDEX_W = 2;
	localparam int POS_W       = 32;
	localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
	// wide enough for any pattern index up to the largest window depth
	localparam int IDX_W       = 7;

	// configuration register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PATTERN_LENGTH = 2'd0,
		REG_PATTERN_LOW    = 2'd1,
		REG_PATTERN_HIGH   = 2'd2
	} cfg_reg_t;

	// configuration as seen by the datapath
	typedef struct packed {
		logic [LEN_W-1:0]              len;
		logic [PAT_BYTES-1:0][7:0]     pat;
	} cfg_t;

	// clamp the written length to the window depth
	function automatic logic [LEN_W-1:0] clamp_len(input logic [CFG_LEN_W-1:0] l);
		if (int'(l) > PATTERN_MAX)
			return LEN_W'(PATTERN_MAX);
		else
			return LEN_W'(l);
	endfunction

	// pattern byte by index, zero beyond the store
	function automatic logic [7:0] pattern_byte(input logic [PAT_BYTES-1:0][7:0] pat,
		input logic [IDX_W-1:0] j);
		if (j < IDX_W'(PAT_BYTES))
			return pat[j[$clog2(PAT_BYTES)-1:0]];
		else
			return 8'd0;
	endfunction

endpackage

FILE: sv/substring_stream_matcher.sv
// Streamed first-occurrence search of a pattern of up to 16 bytes. The block takes one text byte
// per cycle with no gaps of its own: a row of 16 window cells shifts the newest byte in while
// each cell compares the byte it receives against its pattern byte, and the row of compares is
// reduced in the same cycle. The single result of a text (found with its start position, or not
// found at the byte marked last) appears in the output register in the cycle after the byte that
// caused it; a new byte is accepted whenever that register is empty or being taken. Bytes after
// a match are absorbed until the last byte, which clears the window and the byte count for the
// next text. The byte count saturates at its maximum. Configuration writes are taken every cycle.
module substring_stream_matcher (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ssm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [ssm_pkg::CFG_DATA_W-1:0]  cfg_data,
	// text input
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [7:0]                      text_byte,
	input  logic                            last_byte,
	// result output
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            found,
	output logic [ssm_pkg::POS_W-1:0]       match_position
);
	import ssm_pkg::*;

	cfg_t cfg;

	logic                   in_fire;
	logic                   advance;
	logic [COUNT_WIDTH-1:0] seen_q;
	logic [COUNT_WIDTH-1:0] seen_next;
	logic                   done_q;
	logic [PATTERN_MAX:0][7:0] chain;
	logic [PATTERN_MAX-1:0] cell_match;
	logic                   all_match;
	logic                   hit_empty;
	logic                   hit;
	logic                   emit;
	logic [POS_W-1:0]       pos;
	logic                   out_valid_q;
	logic                   found_q;
	logic [POS_W-1:0]       pos_q;

	// configuration registers
	assign cfg_ready = 1'b1;

	ssm_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// input handshake, output register frees the input side
	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;
	assign advance  = in_fire && !done_q;

	// row of window cells, cell i holds the i-th newest byte
	assign chain[0] = text_byte;

	for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
		logic [IDX_W-1:0] idx;
		logic             active;

		assign active = IDX_W'(i) < IDX_W'(cfg.len);
		assign idx    = IDX_W'(cfg.len) - IDX_W'(1) - IDX_W'(i);

		ssm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.advance  (advance),
			.clear    (in_fire && last_byte),
			.byte_in  (chain[i]),
			.expected (pattern_byte(cfg.pat, idx)),
			.active   (active),
			.byte_out (chain[i+1]),
			.match    (cell_match[i])
		);
	end

	assign all_match = &cell_match;

	// saturating byte count including the current byte
	assign seen_next = (seen_q != '1) ? seen_q + COUNT_WIDTH'(1) : seen_q;

	// match decision and result payload
	always_comb begin
		hit_empty = (cfg.len == '0);
		hit       = !hit_empty && all_match && (seen_next >= COUNT_WIDTH'(cfg.len));
		emit      = !done_q && (hit_empty || hit || last_byte);
		pos       = hit ? POS_W'(seen_next - COUNT_WIDTH'(cfg.len)) : '0;
	end

	// text state: count and done flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			done_q <= 1'b0;
		end else if (in_fire) begin
			if (last_byte) begin
				seen_q <= '0;
				done_q <= 1'b0;
			end else if (!done_q) begin
				seen_q <= seen_next;
				done_q <= hit_empty || hit;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && emit) begin
			found_q <= hit_empty || hit;
			pos_q   <= pos;
		end
	end

	assign out_valid      = out_valid_q;
	assign found          = found_q;
	assign match_position = pos_q;

`ifndef ASSERT_OFF
	// a not-found result carries position zero
	a_notfound_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !found_q |-> pos_q == '0)
		else $error("not-found result with nonzero position");

	// the last byte leaves a clean text state
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && last_byte |=> seen_q == '0 && !done_q)
		else $error("text state not cleared after last byte");

	// the search only closes together with a found result
	a_done_with_found: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done_q) |-> out_valid_q && found_q)
		else $error("search closed without a found result");

	// a new result only follows an accepted item
	a_result_from_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(in_fire))
		else $error("result appeared without an accepted item");
`endif

endmodule

FILE: sv/ssm_cfg_regs.sv
// configuration registers: pattern length and pattern bytes
module ssm_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [ssm_pkg::CFG_INDEX_W-1:0] wr_index,
	input  logic [ssm_pkg::CFG_DATA_W-1:0]  wr_data,
	output ssm_pkg::cfg_t                  cfg
);
	import ssm_pkg::*;

	logic [CFG_LEN_W-1:0]  len_q;
	logic [CFG_DATA_W-1:0] low_q;
	logic [CFG_DATA_W-1:0] high_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= CFG_LEN_W'(1);
			low_q  <= '0;
			high_q <= '0;
		end else if (wr_en) begin
			unique case (cfg_reg_t'(wr_index))
				REG_PATTERN_LENGTH: len_q  <= wr_data[CFG_LEN_W-1:0];
				REG_PATTERN_LOW:    low_q  <= wr_data;
				REG_PATTERN_HIGH:   high_q <= wr_data;
				default: ;
			endcase
		end
	end

	// clamped length and byte view of the pattern
	assign cfg.len = clamp_len(len_q);
	assign cfg.pat = {high_q, low_q};

endmodule

FILE: sv/ssm_cell.sv
// one window cell: holds a text byte, passes it on, compares the incoming one
module ssm_cell (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  logic       clear,
	input  logic [7:0] byte_in,
	input  logic [7:0] expected,
	input  logic       active,
	output logic [7:0] byte_out,
	output logic       match
);
	logic [7:0] byte_q;

	// shift register stage of the window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (clear) begin
			byte_q <= '0;
		end else if (advance) begin
			byte_q <= byte_in;
		end
	end

	// compare the byte this cell takes on this cycle
	assign match    = !active || (byte_in == expected);
	assign byte_out = byte_q;

endmodule

FILE: verif/tb_top.sv
// self-checking testbench for the substring stream matcher
module tb_top;
	import ssm_pkg::*;

	localparam int RANDOM_ITEMS    = 900;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int STUCK_LIMIT     = 2000;
	localparam int DRAIN_CYCLES    = 4;

	// how an item's expectation is formed
	typedef enum {ROW_SETUP, ROW_PREDICT, ROW_QUIET, ROW_HIT, ROW_MISS} row_kind_t;

	typedef struct {
		row_kind_t    kind;
		logic [4:0]   len;
		logic [127:0] bits;
		logic [7:0]   tbyte;
		logic         tlast;
		logic [31:0]  pos;
	} dir_row_t;

	typedef struct {
		row_kind_t   kind;
		logic [31:0] pos;
	} item_note_t;

	typedef struct packed {
		logic        found;
		logic [31:0] pos;
	} search_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = REG_PATTERN_LENGTH;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] text_byte = '0;
	logic last_byte = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic found;
	logic [POS_W-1:0] match_position;

	substring_stream_matcher dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.text_byte(text_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.found(found),
		.match_position(match_position)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// search state mirrored from accepted writes and items
	logic [4:0]   pat_len = 5'd1;
	logic [127:0] pat_bits = '0;
	logic [7:0]   win [PATTERN_MAX];
	logic [31:0]  seen = '0;
	bit           done = 1'b0;

	item_note_t     item_notes[$];
	search_result_t pending_results[$];
	int             mismatch_count = 0;
	int             stuck_cycles = 0;

	// stimulus side view of the current setting
	logic [4:0]   set_len = 5'd1;
	logic [127:0] set_bits = '0;
	logic [7:0]   syms [3];
	int unsigned  tx_odds = 2;
	int           items_sent = 0;
	bit           calm = 1'b0;
	bit           hold_off_req = 1'b0;

	initial foreach (win[i]) win[i] = '0;

	// one text byte through the naive search
	task automatic search_step(input logic [7:0] b, input logic l, output bit has,
		output search_result_t r);
		int unsigned n;
		bit hit;
		has = 1'b0;
		r = '0;
		if (!done) begin
			n = (pat_len > PATTERN_MAX) ? PATTERN_MAX : pat_len;
			for (int i = PATTERN_MAX - 1; i > 0; i--) win[i] = win[i-1];
			win[0] = b;
			if (seen != '1) seen = seen + 1;
			if (n == 0) begin
				has = 1'b1;
				r.found = 1'b1;
			end else if (seen >= n) begin
				hit = 1'b1;
				for (int k = 0; k < n; k++)
					if (win[n-1-k] != pat_bits[8*k +: 8]) hit = 1'b0;
				if (hit) begin
					has = 1'b1;
					r.found = 1'b1;
					r.pos = seen - n;
				end
			end
			if (has) done = 1'b1;
			else if (l) has = 1'b1;
		end
		// end of text clears the window and count
		if (l) begin
			foreach (win[i]) win[i] = '0;
			seen = '0;
			done = 1'b0;
		end
	endtask

	task automatic note_mismatch(input string what, input search_result_t want,
		input search_result_t got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: %s: expected found=%0b pos=%0d, got found=%0b pos=%0d",
				$time, what, want.found, want.pos, got.found, got.pos);
	endtask

	// check results, mirror writes and items, watch for a stuck run
	always @(posedge clk) begin : monitor
		item_note_t note;
		search_result_t want, got;
		bit has;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got.found = found;
				got.pos = match_position;
				if (pending_results.size() == 0) begin
					note_mismatch("result with none pending", '0, got);
				end else begin
					want = pending_results.pop_front();
					if (want.found !== got.found || want.pos !== got.pos)
						note_mismatch("wrong result", want, got);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_PATTERN_LENGTH: pat_len = cfg_data[4:0];
					REG_PATTERN_LOW:    pat_bits[63:0] = cfg_data;
					REG_PATTERN_HIGH:   pat_bits[127:64] = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				note = item_notes.pop_front();
				search_step(text_byte, last_byte, has, want);
				case (note.kind)
					ROW_PREDICT: if (has) pending_results.push_back(want);
					ROW_HIT:     pending_results.push_back({1'b1, note.pos});
					ROW_MISS:    pending_results.push_back({1'b0, 32'd0});
					default: ;
				endcase
			end
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				stuck_cycles = 0;
			else
				stuck_cycles++;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// receiver: random stall bursts, one long hold-off on request
	initial begin : receiver
		int unsigned odds;
		int unsigned beats;
		odds = 0;
		beats = 0;
		@(posedge clk);
		out_ready <= 1'b1;
		forever begin
			@(posedge clk);
			beats++;
			if (beats % 64 == 0) odds = $urandom_range(0, 3);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				out_ready <= 1'b1;
			end else if (!calm && odds != 0 && $urandom_range(0, 15) < odds) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
				out_ready <= 1'b1;
			end
		end
	end

	// write length, low and high pattern words back to back
	task automatic write_pattern(input logic [4:0] len, input logic [127:0] bits);
		logic [63:0] junk;
		junk = {$urandom, $urandom};
		cfg_valid <= 1'b1;
		cfg_index <= REG_PATTERN_LENGTH;
		cfg_data <= {junk[63:5], len};
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_PATTERN_LOW;
		cfg_data <= bits[63:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_PATTERN_HIGH;
		cfg_data <= bits[127:64];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		set_len = len;
		set_bits = bits;
	endtask

	// offer one text byte and wait until it is taken
	task automatic send_item(input logic [7:0] b, input logic l, input row_kind_t kind,
		input logic [31:0] pos);
		item_note_t note;
		note.kind = kind;
		note.pos = pos;
		if (!calm && tx_odds != 0 && $urandom_range(0, 7) < tx_odds) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid <= 1'b1;
		text_byte <= b;
		last_byte <= l;
		item_notes.push_back(note);
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	// stop offering until every pending result is out
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (item_notes.size() != 0 || pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// random pattern over a small alphabet so that texts can hit it
	task automatic pick_setting();
		int unsigned r;
		logic [4:0] len;
		logic [127:0] bits;
		r = $urandom_range(0, 9);
		case (r)
			0: len = 5'd0;
			1: len = 5'd16;
			2: len = 5'($urandom_range(17, 31));
			3: len = 5'($urandom_range(7, 15));
			default: len = 5'($urandom_range(1, 6));
		endcase
		foreach (syms[i]) syms[i] = 8'($urandom);
		r = $urandom_range(0, 7);
		if (r == 0) syms[0] = 8'h00;
		else if (r == 1) syms[0] = 8'hFF;
		// all-zero or all-one pattern words now and then
		for (int j = 0; j < PAT_BYTES; j++)
			bits[8*j +: 8] = (r < 2) ? syms[0] : syms[$urandom_range(0, 2)];
		write_pattern(len, bits);
	endtask

	// one text: noise, near misses, or the pattern planted somewhere
	task automatic send_text();
		logic [7:0] txt [$];
		int unsigned n, tlen, at, kind;
		bit split;
		n = (set_len > PATTERN_MAX) ? PATTERN_MAX : set_len;
		tlen = ($urandom_range(0, 15) == 0) ? $urandom_range(25, 200) : $urandom_range(1, 24);
		kind = $urandom_range(0, 9);
		if (kind >= 5 && tlen < n) tlen = n + $urandom_range(0, 4);
		for (int i = 0; i < tlen; i++)
			txt.push_back((kind < 2) ? 8'($urandom) : syms[$urandom_range(0, 2)]);
		if (kind >= 5) begin
			at = $urandom_range(0, tlen - n);
			for (int k = 0; k < n; k++) txt[at+k] = set_bits[8*k +: 8];
		end
		// sometimes the pattern changes halfway through a text
		split = ($urandom_range(0, 15) == 0) && tlen >= 2;
		tx_odds = $urandom_range(0, 3);
		foreach (txt[i]) begin
			if (split && i == tlen / 2) begin
				wait_drained();
				pick_setting();
			end
			send_item(txt[i], i == tlen - 1, ROW_PREDICT, '0);
		end
	endtask

	initial begin : stimulus
		dir_row_t dir_rows[$];
		int text_no;
		foreach (syms[i]) syms[i] = '0;
		// reset pattern is one zero byte
		dir_rows.push_back('{ROW_HIT, 5'd0, 128'd0, 8'h00, 1'b0, 32'd0});
		dir_rows.push_back('{ROW_QUIET, 5'd0, 128'd0, 8'hFF, 1'b1, 32'd0});
		dir_rows.push_back('{ROW_MISS, 5'd0, 128'd0, 8'h5A, 1'b1, 32'd0});
		// empty pattern hits on the first byte, also on a last byte
		dir_rows.push_back('{ROW_SETUP, 5'd0, 128'd0, 8'h00, 1'b0, 32'd0});
		dir_rows.push_back('{ROW_HIT, 5'd0, 128'd0, 8'hFF, 1'b0, 32'd0});
		dir_rows.push_back('{ROW_QUIET, 5'd0, 128'd0, 8'h00, 1'b1, 32'd0});
		dir_rows.push_back('{ROW_HIT, 5'd0, 128'd0, 8'h80, 1'b1, 32'd0});
		// three byte pattern after a false start
		dir_rows.push_back('{ROW_SETUP, 5'd3, {64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0043_4241},
			8'h00, 1'b0, 32'd0});
		dir_rows.push_back('{ROW_PREDICT, 5'd0, 128'd0, 8'h41, 1'b0, 32'd0});
		dir_rows.push_back('{ROW_PREDICT, 5'd0, 128'd0, 8'h41, 1'b0, 32'd0});
		dir_rows.push_back('{ROW_PREDICT, 5'd0, 128'd0, 8'h42, 1'b0, 32'd0});
		dir_rows.push_back('{ROW_PREDICT, 5'd0, 128'd0, 8'h43, 1'b0, 32'd0});
		dir_rows.push_back('{ROW_PREDICT, 5'd0, 128'd0, 8'h43, 1'b1, 32'd0});
		// oversized length acts as full window, match lands on the last byte
		dir_rows.push_back('{ROW_SETUP, 5'd31, '1, 8'h00, 1'b0, 32'd0});
		for (int i = 0; i < PATTERN_MAX - 1; i++)
			dir_rows.push_back('{ROW_QUIET, 5'd0, 128'd0, 8'hFF, 1'b0, 32'd0});
		dir_rows.push_back('{ROW_HIT, 5'd0, 128'd0, 8'hFF, 1'b1, 32'd0});

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_SETUP) begin
				wait_drained();
				write_pattern(dir_rows[i].len, dir_rows[i].bits);
			end else begin
				send_item(dir_rows[i].tbyte, dir_rows[i].tlast, dir_rows[i].kind,
					dir_rows[i].pos);
			end
		end

		// random texts under changing patterns
		text_no = 0;
		while (items_sent < RANDOM_ITEMS) begin
			if (text_no % 6 == 0) begin
				wait_drained();
				pick_setting();
			end
			if (text_no == 30) hold_off_req = 1'b1;
			calm = (items_sent + 100 >= RANDOM_ITEMS);
			send_text();
			text_no++;
		end

		wait_drained();
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

FILE: substring_stream_matcher.f
sv/ssm_pkg.sv
sv/ssm_cfg_regs.sv
sv/ssm_cell.sv
sv/substring_stream_matcher.sv
verif/tb_top.sv
